>>> rtl/wspid_pkg.sv
// ----------------------------------------------------------------------------
// wspid_pkg: shared types and constants of the wheel speed PID controller
// Item layouts, op and register codes, reset values and the widths of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package wspid_pkg;

	// op codes of an input item
	localparam logic [1:0] OP_EDGE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_CMD  = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TICK_RATE  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_DUTY_TOP   = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_ENC_INVERT = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_MOT_INVERT = 3'd7;

	// register reset values
	localparam logic signed [15:0] GAIN_P_RST    = -16'sd205;
	localparam logic signed [15:0] GAIN_I_RST    = -16'sd1364;
	localparam logic signed [15:0] GAIN_D_RST    = 16'sd20;
	localparam logic [9:0]         TICK_RATE_RST = 10'd10;
	localparam logic [7:0]         TIMEOUT_RST   = 8'd10;
	localparam logic [15:0]        DUTY_TOP_RST  = 16'd2499;

	// widths fixed by the field ranges
	localparam int unsigned RATE_W    = 10;
	localparam int unsigned DEN_W     = RATE_W + 1;
	localparam int unsigned ERR_W     = 26;
	localparam int unsigned DR_W      = 37;
	localparam int unsigned INTEG_W   = 48;
	localparam int unsigned SUM_W     = 64;
	localparam int unsigned TERM_LOG2 = 61;
	localparam logic [7:0]  SILENCE_MAX = 8'hFF;

	// shared multiply-accumulate unit: 17 x 48 bits as two 17 x 25 passes
	localparam int unsigned MAC_A_W     = 17;
	localparam int unsigned MAC_B_W     = 48;
	localparam int unsigned MAC_CHUNK   = 24;
	localparam int unsigned MAC_ACC_W   = 66;
	localparam int unsigned MAC_PROD_W  = MAC_A_W + MAC_CHUNK + 1;

	typedef struct packed {
		logic [1:0]         op;
		logic               chan_a_level;
		logic               chan_b_level;
		logic signed [15:0] target_rate;
	} item_t;

	typedef struct packed {
		logic               fwd_pin;
		logic               rev_pin;
		logic [15:0]        pwm_level;
		logic signed [15:0] pulses_per_tick;
		logic signed [31:0] position_count;
		logic               timed_out;
	} result_t;

	typedef struct packed {
		logic                         start;
		logic signed [MAC_A_W-1:0]    a;
		logic signed [MAC_B_W-1:0]    b;
		logic signed [MAC_ACC_W-1:0]  init;
	} mac_req_t;

	typedef struct packed {
		logic                         done;
		logic signed [MAC_ACC_W-1:0]  acc;
	} mac_rsp_t;

endpackage

>>> rtl/wspid_mac.sv
// ----------------------------------------------------------------------------
// wspid_mac: shared multiply-accumulate unit
// Latches a 17-bit and a 48-bit signed operand and adds their product to an
// initial value, one 24-bit slice of the wide operand per cycle.
// ----------------------------------------------------------------------------
module wspid_mac import wspid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_req_t req,
	output mac_rsp_t rsp
);

	logic                          busy_q;
	logic                          hi_q;
	logic                          done_q;
	logic signed [MAC_A_W-1:0]     a_q;
	logic signed [MAC_B_W-1:0]     b_q;
	logic signed [MAC_ACC_W-1:0]   acc_q;
	logic signed [MAC_CHUNK:0]     chunk;
	logic signed [MAC_PROD_W-1:0]  prod;
	logic signed [MAC_ACC_W-1:0]   prod_ext;
	logic signed [MAC_ACC_W-1:0]   addend;

	// low slice is unsigned, high slice carries the sign
	assign chunk    = hi_q ? {b_q[MAC_B_W-1], b_q[MAC_B_W-1 -: MAC_CHUNK]}
			: {1'b0, b_q[MAC_CHUNK-1:0]};
	assign prod     = a_q * chunk;
	assign prod_ext = MAC_ACC_W'(prod);
	assign addend   = hi_q ? (prod_ext <<< MAC_CHUNK) : prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			hi_q <= ~hi_q;
			if (hi_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= req.init;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
		end
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiply started while busy");

endmodule

>>> rtl/wspid_div.sv
// ----------------------------------------------------------------------------
// wspid_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; done stays high until the
// next start.
// ----------------------------------------------------------------------------
module wspid_div import wspid_pkg::*; #(
	parameter int unsigned NUM_W = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// shift the next dividend bit into the remainder and try a subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("division started while busy");

endmodule

>>> rtl/wheel_speed_pid_controller_unit.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid_controller_unit: speed loop for one wheel
// Quadrature edge counting, a command watchdog and a fixed-point PID with a
// trapezoidal integral, worked out on one shared multiply-accumulate unit and
// a bit-serial divider under a small sequencer.
//
//   channel  direction  handshake                payload
//   in       in         in_valid / in_ready      in_item   (item_t)
//   out      out        out_valid / out_ready    out_item  (result_t)
//   cfg      in         cfg_wr_en, no wait       cfg_addr, cfg_wdata
//
// Edges and commands are taken while idle and give no result. A tick holds
// in_ready low from acceptance until its result is loaded; the serial
// divider (one quotient bit a cycle over 26 + GAIN_FRAC_BITS bits) takes
// most of that time. A result waiting in the output register holds the
// next tick at its last step, with in_ready low.
// Reset clears the counters, the PID state and loads the register defaults.
// ----------------------------------------------------------------------------
module wheel_speed_pid_controller_unit import wspid_pkg::*; #(
	parameter int unsigned COUNT_BITS     = 32,
	parameter int unsigned GAIN_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  item_t                 in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_item,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned NUM_W  = ERR_W + GAIN_FRAC_BITS;
	localparam int unsigned MAG_W  = SUM_W - 2 * GAIN_FRAC_BITS;
	localparam int unsigned DLIM_LOG2 = TERM_LOG2 - GAIN_FRAC_BITS;
	localparam logic signed [MAC_ACC_W-1:0] T_LIM = MAC_ACC_W'(1) << TERM_LOG2;
	localparam logic signed [MAC_ACC_W-1:0] D_LIM = MAC_ACC_W'(1) << DLIM_LOG2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR_GO,
		S_ERR_W,
		S_P_GO,
		S_P_W,
		S_DR_GO,
		S_DR_W,
		S_D_GO,
		S_D_W,
		S_DIV_W,
		S_I_GO,
		S_I_W,
		S_OUT
	} state_t;

	// configuration registers
	logic signed [15:0] gain_p_q;
	logic signed [15:0] gain_i_q;
	logic signed [15:0] gain_d_q;
	logic [RATE_W-1:0]  tick_rate_q;
	logic [7:0]         timeout_q;
	logic [15:0]        duty_top_q;
	logic               enc_inv_q;
	logic               mot_inv_q;

	// loop state
	state_t                    state_q;
	logic [COUNT_BITS-1:0]     edge_q;
	logic [COUNT_BITS-1:0]     last_q;
	logic signed [15:0]        target_hold_q;
	logic [7:0]                silence_q;
	logic signed [ERR_W-1:0]   err_now_q;
	logic signed [ERR_W-1:0]   err_prev_q;
	logic signed [INTEG_W-1:0] integ_q;

	// per-tick working registers
	logic signed [15:0]        pulses_q;
	logic                      timed_q;
	logic signed [15:0]        target_q;
	logic [RATE_W-1:0]         rate_q;
	logic signed [DR_W-1:0]    dr_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      out_valid_q;
	result_t                   out_q;

	// combinational helpers
	logic                         edge_up;
	logic [COUNT_BITS-1:0]        edge_step;
	logic signed [COUNT_BITS-1:0] diff_s;
	logic signed [COUNT_BITS-1:0] edge_s;
	logic [COUNT_BITS-16:0]       diff_top;
	logic signed [15:0]           pulses_sat;
	logic                         timed;
	logic signed [ERR_W:0]        err_sum;
	logic signed [ERR_W:0]        err_diff;
	logic [ERR_W:0]               err_mag;
	logic [NUM_W-1:0]             div_num;
	logic [DEN_W-1:0]             div_den;
	logic                         div_start;
	logic                         div_done;
	logic [NUM_W-1:0]             div_quo;
	logic signed [INTEG_W:0]      quo_ext;
	logic signed [INTEG_W:0]      integ_inc;
	logic signed [INTEG_W:0]      integ_sum;
	logic signed [INTEG_W-1:0]    integ_next;
	logic signed [MAC_ACC_W-1:0]  d_clip;
	logic signed [MAC_ACC_W-1:0]  i_clip;
	logic signed [SUM_W-1:0]      p_term;
	logic signed [SUM_W-1:0]      d_term;
	logic signed [SUM_W-1:0]      i_term;
	logic [SUM_W-1:0]             sum_abs;
	logic [MAG_W-1:0]             mag_full;
	logic [15:0]                  pwm;
	logic                         drv_pos;
	logic                         drv_neg;
	mac_req_t                     mac_req;
	mac_rsp_t                     mac_rsp;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// configuration port: take a write whenever enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			tick_rate_q <= TICK_RATE_RST;
			timeout_q   <= TIMEOUT_RST;
			duty_top_q  <= DUTY_TOP_RST;
			enc_inv_q   <= 1'b0;
			mot_inv_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_GAIN_P:     gain_p_q    <= cfg_wdata;
				REG_GAIN_I:     gain_i_q    <= cfg_wdata;
				REG_GAIN_D:     gain_d_q    <= cfg_wdata;
				REG_TICK_RATE:  tick_rate_q <= cfg_wdata[RATE_W-1:0];
				REG_TIMEOUT:    timeout_q   <= cfg_wdata[7:0];
				REG_DUTY_TOP:   duty_top_q  <= cfg_wdata;
				REG_ENC_INVERT: enc_inv_q   <= cfg_wdata[0];
				REG_MOT_INVERT: mot_inv_q   <= cfg_wdata[0];
			endcase
		end
	end

	// Encoder: count up when the channels agree, down otherwise, reversed
	// if configured. The count wraps at COUNT_BITS.
	assign edge_up   = (in_item.chan_a_level == in_item.chan_b_level) ^ enc_inv_q;
	assign edge_step = edge_up ? edge_q + COUNT_BITS'(1) : edge_q - COUNT_BITS'(1);

	// Pulses since the last tick, wrapped then saturated to 16 bits signed.
	// The top bits must all match the sign for the value to fit.
	assign diff_s   = edge_q - last_q;
	assign diff_top = diff_s[COUNT_BITS-1:15];
	always_comb begin
		if ((&diff_top) || !(|diff_top)) begin
			pulses_sat = diff_s[15:0];
		end else if (diff_s[COUNT_BITS-1]) begin
			pulses_sat = 16'sh8000;
		end else begin
			pulses_sat = 16'sh7FFF;
		end
	end

	// Watchdog: compare before the silence counter advances.
	assign timed = (silence_q > timeout_q);

	// Trapezoid numerator: |e_now + e_prev| scaled by the gain fraction;
	// the divisor is twice the tick rate. Quotient truncates toward zero.
	assign err_sum   = (ERR_W+1)'(err_now_q) + (ERR_W+1)'(err_prev_q);
	assign err_diff  = (ERR_W+1)'(err_now_q) - (ERR_W+1)'(err_prev_q);
	assign err_mag   = err_sum[ERR_W] ? -err_sum : err_sum;
	assign div_num   = {err_mag[ERR_W-1:0], {GAIN_FRAC_BITS{1'b0}}};
	assign div_den   = {rate_q, 1'b0};
	assign div_start = (state_q == S_P_GO);

	assign quo_ext    = (INTEG_W+1)'(div_quo);
	assign integ_inc  = err_sum[ERR_W] ? -quo_ext : quo_ext;
	assign integ_sum  = (INTEG_W+1)'(integ_q) + integ_inc;
	always_comb begin
		if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W-1:0];
		end else if (integ_sum[INTEG_W]) begin
			integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
		end else begin
			integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
		end
	end

	// PID terms at Q.2F from the multiply result. Clamp D before scaling
	// and I directly at the term limit.
	assign p_term = SUM_W'(mac_rsp.acc) <<< GAIN_FRAC_BITS;
	always_comb begin
		if (mac_rsp.acc > D_LIM) begin
			d_clip = D_LIM;
		end else if (mac_rsp.acc < -D_LIM) begin
			d_clip = -D_LIM;
		end else begin
			d_clip = mac_rsp.acc;
		end
		if (mac_rsp.acc > T_LIM) begin
			i_clip = T_LIM;
		end else if (mac_rsp.acc < -T_LIM) begin
			i_clip = -T_LIM;
		end else begin
			i_clip = mac_rsp.acc;
		end
	end
	assign d_term = SUM_W'(d_clip) <<< GAIN_FRAC_BITS;
	assign i_term = SUM_W'(i_clip);

	// Drive level: magnitude of the sum dropped to an integer, held at
	// duty_top. Direction pins swap under motor inversion.
	assign sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign mag_full = MAG_W'(sum_abs >> (2 * GAIN_FRAC_BITS));
	assign pwm      = (mag_full > MAG_W'(duty_top_q)) ? duty_top_q : mag_full[15:0];
	assign drv_pos  = !sum_q[SUM_W-1] && (sum_q != '0);
	assign drv_neg  = sum_q[SUM_W-1];
	assign edge_s   = edge_q;

	// operand selection for the shared multiplier
	always_comb begin
		mac_req = '0;
		unique case (state_q)
			S_ERR_GO: begin
				// rate = pulses * tick_rate - target
				mac_req.start = 1'b1;
				mac_req.a     = MAC_A_W'(rate_q);
				mac_req.b     = MAC_B_W'(pulses_q);
				mac_req.init  = -(MAC_ACC_W'(target_q));
			end
			S_P_GO: begin
				mac_req.start = 1'b1;
				mac_req.a     = MAC_A_W'(gain_p_q);
				mac_req.b     = MAC_B_W'(err_now_q);
			end
			S_DR_GO: begin
				mac_req.start = 1'b1;
				mac_req.a     = MAC_A_W'(rate_q);
				mac_req.b     = MAC_B_W'(err_diff);
			end
			S_D_GO: begin
				mac_req.start = 1'b1;
				mac_req.a     = MAC_A_W'(gain_d_q);
				mac_req.b     = MAC_B_W'(dr_q);
			end
			S_I_GO: begin
				mac_req.start = 1'b1;
				mac_req.a     = MAC_A_W'(gain_i_q);
				mac_req.b     = integ_q;
			end
			default: ;
		endcase
	end

	wspid_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	wspid_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequencer: edges and commands finish on acceptance; a tick walks the
	// error, P, D, integral and I steps, then waits for the output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			edge_q        <= '0;
			last_q        <= '0;
			target_hold_q <= '0;
			silence_q     <= '0;
			err_now_q     <= '0;
			err_prev_q    <= '0;
			integ_q       <= '0;
			pulses_q      <= '0;
			timed_q       <= 1'b0;
			target_q      <= '0;
			rate_q        <= TICK_RATE_RST;
			dr_q          <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			// drop the result once taken; the output step reloads it itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (in_item.op)
							OP_EDGE: edge_q <= edge_step;
							OP_CMD: begin
								target_hold_q <= in_item.target_rate;
								silence_q     <= '0;
							end
							OP_TICK: begin
								pulses_q   <= pulses_sat;
								timed_q    <= timed;
								target_q   <= timed ? '0 : target_hold_q;
								if (silence_q != SILENCE_MAX) begin
									silence_q <= silence_q + 8'd1;
								end
								err_prev_q <= err_now_q;
								rate_q     <= (tick_rate_q == '0) ? RATE_W'(1) : tick_rate_q;
								last_q     <= edge_q;
								state_q    <= S_ERR_GO;
							end
							default: ;
						endcase
					end
				end
				S_ERR_GO: state_q <= S_ERR_W;
				S_ERR_W: begin
					if (mac_rsp.done) begin
						err_now_q <= ERR_W'(mac_rsp.acc);
						state_q   <= S_P_GO;
					end
				end
				S_P_GO: state_q <= S_P_W;
				S_P_W: begin
					if (mac_rsp.done) begin
						sum_q   <= p_term;
						state_q <= S_DR_GO;
					end
				end
				S_DR_GO: state_q <= S_DR_W;
				S_DR_W: begin
					if (mac_rsp.done) begin
						dr_q    <= DR_W'(mac_rsp.acc);
						state_q <= S_D_GO;
					end
				end
				S_D_GO: state_q <= S_D_W;
				S_D_W: begin
					if (mac_rsp.done) begin
						sum_q   <= sum_q + d_term;
						state_q <= S_DIV_W;
					end
				end
				S_DIV_W: begin
					if (div_done) begin
						integ_q <= integ_next;
						state_q <= S_I_GO;
					end
				end
				S_I_GO: state_q <= S_I_W;
				S_I_W: begin
					if (mac_rsp.done) begin
						sum_q   <= sum_q + i_term;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold here until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.fwd_pin         <= mot_inv_q ? drv_neg : drv_pos;
						out_q.rev_pin         <= mot_inv_q ? drv_pos : drv_neg;
						out_q.pwm_level       <= pwm;
						out_q.pulses_per_tick <= pulses_q;
						out_q.position_count  <= 32'(edge_s);
						out_q.timed_out       <= timed_q;
						out_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output step");

	a_edge_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && in_item.op == OP_EDGE) |=> $stable(edge_q))
		else $error("encoder count moved without an edge item");

	a_silence_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(silence_q == SILENCE_MAX && !(in_valid && in_ready && in_item.op == OP_CMD))
		|=> silence_q == SILENCE_MAX)
		else $error("silence counter left its ceiling without a command");

endmodule

>>> tb/sv/wheel_speed_pid_controller_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_pid_controller_checker: drive prediction and result compare
// Mirrors the register port and the input channel, works out the drive for
// every accepted tick and compares each accepted result, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module wheel_speed_pid_controller_checker import wspid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  item_t                 in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  result_t               out_item,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    pending
);

	localparam int     FRAC      = 8;
	localparam longint SCALE     = 64'sd1 << FRAC;
	localparam longint TERM_LIM  = 64'sd1 << 61;
	localparam longint INTEG_HI  = (64'sd1 << 47) - 64'sd1;
	localparam longint INTEG_LO  = -(64'sd1 << 47);

	// register mirror
	logic signed [15:0] kp, ki, kd;
	logic [9:0]         rate;
	logic [7:0]         timeout_lim;
	logic [15:0]        duty_max;
	logic               enc_inv, mot_inv;

	// loop state
	logic [31:0]        enc_count, enc_at_tick;
	logic signed [15:0] target_hold;
	int                 err_now, err_prev;
	longint             integ;
	logic [7:0]         silent;

	result_t drive_q[$];

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic flag_error(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_drive(input result_t got, input result_t want);
		if (got.fwd_pin !== want.fwd_pin)
			flag_error($sformatf("fwd_pin: got %0d, expected %0d", got.fwd_pin, want.fwd_pin));
		if (got.rev_pin !== want.rev_pin)
			flag_error($sformatf("rev_pin: got %0d, expected %0d", got.rev_pin, want.rev_pin));
		if (got.pwm_level !== want.pwm_level)
			flag_error($sformatf("pwm_level: got %0d, expected %0d",
				got.pwm_level, want.pwm_level));
		if (got.pulses_per_tick !== want.pulses_per_tick)
			flag_error($sformatf("pulses_per_tick: got %0d, expected %0d",
				got.pulses_per_tick, want.pulses_per_tick));
		if (got.position_count !== want.position_count)
			flag_error($sformatf("position_count: got %0d, expected %0d",
				got.position_count, want.position_count));
		if (got.timed_out !== want.timed_out)
			flag_error($sformatf("timed_out: got %0d, expected %0d",
				got.timed_out, want.timed_out));
	endtask

	// One control tick: measure, run the watchdog, step the PID, queue the drive.
	task automatic predict_tick();
		longint  rdiv, pulses, tgt, inc, p_t, i_t, d_t, total, mag;
		int      moved;
		logic    timed;
		result_t r;
		rdiv   = (rate == '0) ? 64'sd1 : longint'(rate);
		moved  = $signed(enc_count - enc_at_tick);
		pulses = clamp_to(moved, -64'sd32768, 64'sd32767);
		timed  = silent > timeout_lim;
		tgt    = timed ? 64'sd0 : longint'(target_hold);
		if (silent != SILENCE_MAX)
			silent++;

		err_prev = err_now;
		err_now  = int'(pulses * rdiv - tgt);

		// trapezoidal step, truncated toward zero
		inc   = (longint'(err_now) + longint'(err_prev)) * SCALE / (2 * rdiv);
		integ = clamp_to(integ + inc, INTEG_LO, INTEG_HI);

		p_t = longint'(kp) * longint'(err_now) * SCALE;
		i_t = clamp_to(longint'(ki) * integ, -TERM_LIM, TERM_LIM);
		d_t = clamp_to(longint'(kd) * (longint'(err_now) - longint'(err_prev)) * rdiv,
			-(TERM_LIM / SCALE), TERM_LIM / SCALE) * SCALE;
		total = p_t + i_t + d_t;

		mag = (total < 0) ? -total : total;
		mag = mag >>> (2 * FRAC);
		if (mag > longint'(duty_max))
			mag = longint'(duty_max);

		r.fwd_pin         = mot_inv ? (total < 0) : (total > 0);
		r.rev_pin         = mot_inv ? (total > 0) : (total < 0);
		r.pwm_level       = mag[15:0];
		r.pulses_per_tick = pulses[15:0];
		r.position_count  = enc_count;
		r.timed_out       = timed;
		enc_at_tick = enc_count;
		drive_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp          = GAIN_P_RST;
			ki          = GAIN_I_RST;
			kd          = GAIN_D_RST;
			rate        = TICK_RATE_RST;
			timeout_lim = TIMEOUT_RST;
			duty_max    = DUTY_TOP_RST;
			enc_inv     = 1'b0;
			mot_inv     = 1'b0;
			enc_count   = '0;
			enc_at_tick = '0;
			target_hold = '0;
			err_now     = 0;
			err_prev    = 0;
			integ       = 0;
			silent      = '0;
			drive_q.delete();
			mismatches  = 0;
			pending     = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0)
					flag_error($sformatf("result with none expected: pwm_level %0d",
						out_item.pwm_level));
				else
					compare_drive(out_item, drive_q.pop_front());
			end
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_GAIN_P:     kp = cfg_wdata;
					REG_GAIN_I:     ki = cfg_wdata;
					REG_GAIN_D:     kd = cfg_wdata;
					REG_TICK_RATE:  rate = cfg_wdata[RATE_W-1:0];
					REG_TIMEOUT:    timeout_lim = cfg_wdata[7:0];
					REG_DUTY_TOP:   duty_max = cfg_wdata;
					REG_ENC_INVERT: enc_inv = cfg_wdata[0];
					REG_MOT_INVERT: mot_inv = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (in_item.op)
					OP_EDGE: begin
						if ((in_item.chan_a_level == in_item.chan_b_level) ^ enc_inv)
							enc_count = enc_count + 32'd1;
						else
							enc_count = enc_count - 32'd1;
					end
					OP_TICK: predict_tick();
					OP_CMD: begin
						target_hold = in_item.target_rate;
						silent      = '0;
					end
					default: ;
				endcase
			end
			pending = drive_q.size();
		end
	end

endmodule

>>> tb/sv/wheel_speed_pid_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_pid_controller_unit_test: top of the speed loop testbench
// Drives encoder edges, control ticks and commands into the block under a
// run of register settings, with random idling on both channels and one long
// hold-off of the receiver. The checker beside the block predicts every
// drive result; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module wheel_speed_pid_controller_unit_test;
	import wspid_pkg::*;

	// op value the block has no use for; it must be ignored
	localparam logic [1:0] OP_SPARE = 2'd3;
	// margin after the last result before touching registers
	localparam int SETTLE_CYCLES = 64;
	// cycles with nothing accepted before the run is declared hung
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 90;
	localparam int PHASES        = 7;
	localparam int HOLD_CYCLES   = 400;
	localparam int LONG_TICKS    = 260;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	item_t                 in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	result_t               out_item;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int   mismatches;
	int   pending;
	logic in_taken;
	int   quiet_cycles  = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_request  = 0;
	int   items_sent    = 0;

	always #5 clk = ~clk;

	wheel_speed_pid_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	wheel_speed_pid_controller_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Register the input handshake so the driver, working on the falling
	// edge, sees a settled record of what the last rising edge accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_taken <= 1'b0;
		else
			in_taken <= in_valid && in_ready;
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: stall at random, or hold off for a whole stretch on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic item_t make_item(input logic [1:0] op, input logic a, input logic b,
			input logic [15:0] tgt);
		item_t it;
		it.op           = op;
		it.chan_a_level = a;
		it.chan_b_level = b;
		it.target_rate  = tgt;
		return it;
	endfunction

	// Modest rates in four picks of ten; extremes, zero and full-range values fill the rest.
	function automatic logic [15:0] pick_target();
		case ($urandom_range(9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3, 4, 5: return 16'($urandom);
			default: return 16'(int'($urandom_range(600)) - 300);
		endcase
	endfunction

	// Offer one item: idle first if the sender is in an idling mood, then
	// hold valid and the payload until the block takes the item.
	task automatic offer_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(negedge clk); while (!in_taken);
		if (it.op != OP_SPARE)
			items_sent++;
	endtask

	// Edge with channels equal (count up unless inverted) or different.
	task automatic offer_edge(input logic same);
		logic a;
		a = 1'($urandom);
		offer_item(make_item(OP_EDGE, a, same ? a : ~a, 16'($urandom)));
	endtask

	task automatic offer_tick();
		offer_item(make_item(OP_TICK, 1'($urandom), 1'($urandom), 16'($urandom)));
	endtask

	// Mostly a realistic burst (maybe a command, edges with a prevailing
	// direction, then a tick); now and then a handful of arbitrary items.
	task automatic offer_sequence();
		int   edges;
		logic same;
		if ($urandom_range(99) < 85) begin
			if ($urandom_range(99) < 40)
				offer_item(make_item(OP_CMD, 1'($urandom), 1'($urandom), pick_target()));
			edges = $urandom_range(12);
			same  = 1'($urandom);
			repeat (edges) begin
				if ($urandom_range(99) < 80)
					offer_edge(same);
				else
					offer_edge(~same);
			end
			offer_tick();
		end else begin
			repeat ($urandom_range(4, 1))
				offer_item(make_item(2'($urandom), 1'($urandom), 1'($urandom),
					16'($urandom)));
		end
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 19;
				recv_idle_pct = 58;
			end
			1: begin
				send_idle_pct = 58;
				recv_idle_pct = 19;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Drop valid, wait for every predicted result, then let any edge or
	// command still in flight finish.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write enable stays high across back-to-back writes; drop it after the last.
	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	task automatic load_setting(input int k);
		logic [15:0] v [8];
		case (k)
			// defaults with both inversions on
			0: v = '{16'hFF33, 16'hFAAC, 16'd20, 16'd10, 16'd10, 16'd2499, 16'd1, 16'd1};
			// largest gains, fastest ticks, a watchdog that never expires
			1: v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1000, 16'd255, 16'hFFFF,
				16'd0, 16'd1};
			// most negative gains, slowest ticks, a watchdog limit of one, tiny top
			2: v = '{16'h8000, 16'h8000, 16'h8000, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0};
			// stray high bits: tick rate lands on zero, inversions on off
			3: v = '{16'h0100, 16'h0000, 16'h0000, 16'hFC00, 16'hAB05, 16'd4000,
				16'hFFFE, 16'hFFFE};
			default: begin
				v[REG_GAIN_P]     = 16'($urandom);
				v[REG_GAIN_I]     = 16'($urandom);
				v[REG_GAIN_D]     = 16'($urandom);
				v[REG_TICK_RATE]  = 16'($urandom_range(1000, 1));
				v[REG_TIMEOUT]    = 16'($urandom_range(255, 1));
				v[REG_DUTY_TOP]   = 16'($urandom_range(65535, 1));
				v[REG_ENC_INVERT] = 16'($urandom);
				v[REG_MOT_INVERT] = 16'($urandom);
			end
		endcase
		cfg_write(REG_GAIN_P,     v[REG_GAIN_P]);
		cfg_write(REG_GAIN_I,     v[REG_GAIN_I]);
		cfg_write(REG_GAIN_D,     v[REG_GAIN_D]);
		cfg_write(REG_TICK_RATE,  v[REG_TICK_RATE]);
		cfg_write(REG_TIMEOUT,    v[REG_TIMEOUT]);
		cfg_write(REG_DUTY_TOP,   v[REG_DUTY_TOP]);
		cfg_write(REG_ENC_INVERT, v[REG_ENC_INVERT]);
		cfg_write(REG_MOT_INVERT, v[REG_MOT_INVERT]);
		cfg_wr_en <= 1'b0;
	endtask

	// Directed opening under the reset settings: a tick with no motion,
	// every channel combination, extreme commands, an ignored op and a
	// watchdog that runs out.
	task automatic run_directed();
		offer_item(make_item(OP_TICK, 1'b0, 1'b0, 16'h0000));
		offer_item(make_item(OP_EDGE, 1'b0, 1'b0, 16'h0000));
		offer_item(make_item(OP_EDGE, 1'b1, 1'b1, 16'hFFFF));
		offer_item(make_item(OP_EDGE, 1'b0, 1'b1, 16'h0000));
		offer_item(make_item(OP_EDGE, 1'b1, 1'b0, 16'hFFFF));
		offer_tick();
		offer_item(make_item(OP_CMD, 1'b0, 1'b0, 16'h7FFF));
		offer_tick();
		offer_item(make_item(OP_CMD, 1'b1, 1'b1, 16'h8000));
		offer_tick();
		offer_item(make_item(OP_SPARE, 1'b1, 1'b1, 16'h5A5A));
		offer_tick();
		offer_item(make_item(OP_CMD, 1'b0, 1'b1, 16'd1000));
		// twelve silent ticks: the last one finds the watchdog expired
		repeat (12) offer_tick();
	endtask

	initial begin
		int goal;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_idle(0);
		run_directed();

		for (int ph = 0; ph < PHASES; ph++) begin
			// sender light and receiver heavy, then swapped, then no idling
			set_idle((ph < 3) ? 0 : ((ph < 5) ? 1 : 2));
			drain();
			load_setting(ph);

			// hold the watchdog at its ceiling: with a limit of 255 it never fires
			if (ph == 1) begin
				offer_item(make_item(OP_CMD, 1'b0, 1'b0, pick_target()));
				repeat (LONG_TICKS) offer_tick();
			end

			// stop the receiver for a long stretch while items keep coming,
			// so a second tick backs up behind the held result
			if (ph == 2)
				hold_request = HOLD_CYCLES;

			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal)
				offer_sequence();
		end

		drain();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
